[rtl/core/hlva_pkg.sv]
// shared types, constants and coefficient function for the hough line vote accumulator
`timescale 1ns / 1ps
`default_nettype none

package hlva_pkg;

    // coefficient format: signed Q1.16, needs 18 bits to hold +/-65536
    localparam int COEF_W = 18;
    localparam int FRAC_BITS = 16;

    // one-degree rotation step in Q2.30
    localparam longint ROT_COS = 64'sd1073578288;
    localparam longint ROT_SIN = 64'sd18739379;
    localparam longint Q30_ONE = 64'sd1073741824;

    // input item
    typedef struct packed {
        logic       req_type;
        logic [6:0] point_x;
        logic [6:0] point_y;
        logic [1:0] angle_index;
        logic [8:0] radius_index;
    } in_t;

    // result item
    typedef struct packed {
        logic [15:0] vote_count;
        logic        is_peak;
    } out_t;

    // classified command held in the queue
    typedef struct packed {
        logic       is_read;
        logic       ok;
        logic [6:0] point_x;
        logic [6:0] point_y;
        logic [1:0] angle_index;
        logic [8:0] radius_index;
    } cmd_t;

    // request codes
    localparam logic REQ_VOTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // divide by 2^sh, rounding half away from zero
    function automatic longint round_shift(input longint v, input int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        if (v < 0) begin
            return -((-v + half) >>> sh);
        end
        return (v + half) >>> sh;
    endfunction

    // Q1.16 cosine or sine at an integer degree, built by repeated rotation
    function automatic logic signed [COEF_W-1:0] unit_coef(input int deg, input logic want_sin);
        longint c;
        longint s;
        longint nc;
        longint ns;
        int     k;
        c = Q30_ONE;
        s = 0;
        for (k = 0; k < deg; k++) begin
            nc = round_shift(c * ROT_COS - s * ROT_SIN, 30);
            ns = round_shift(s * ROT_COS + c * ROT_SIN, 30);
            c = nc;
            s = ns;
        end
        if (want_sin) begin
            return COEF_W'(round_shift(s, 14));
        end
        return COEF_W'(round_shift(c, 14));
    endfunction

endpackage

`default_nettype wire

[rtl/core/hlva_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module hlva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1456
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/hlva_front.sv]
// front end: accepts items, classifies them and queues commands for the back end
`timescale 1ns / 1ps
`default_nettype none

module hlva_front #(
    parameter int ANGLES      = 4,
    parameter int RADIUS_BINS = 364,
    parameter int COORD_RANGE = 128
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire hlva_pkg::in_t  s_data,
    input  wire logic           clearing,
    output logic                q_valid,
    output hlva_pkg::cmd_t      q_cmd,
    input  wire logic           q_pop
);

    localparam int QDEPTH = 2;

    hlva_pkg::cmd_t q_mem_reg [QDEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    logic           coord_ok;
    logic           read_ok;
    logic           keep;
    logic           push;
    hlva_pkg::cmd_t cmd_in;

    assign coord_ok = (9'(s_data.point_x) < 9'(COORD_RANGE))
                   && (9'(s_data.point_y) < 9'(COORD_RANGE));
    assign read_ok  = (8'(s_data.angle_index) < 8'(ANGLES))
                   && (11'(s_data.radius_index) < 11'(RADIUS_BINS));

    // votes with a point off the grid never reach the queue
    assign keep = (s_data.req_type == hlva_pkg::REQ_READ) || coord_ok;

    always_comb begin
        cmd_in.is_read      = (s_data.req_type == hlva_pkg::REQ_READ);
        cmd_in.ok           = (s_data.req_type == hlva_pkg::REQ_READ) ? read_ok : 1'b1;
        cmd_in.point_x      = s_data.point_x;
        cmd_in.point_y      = s_data.point_y;
        cmd_in.angle_index  = s_data.angle_index;
        cmd_in.radius_index = s_data.radius_index;
    end

    assign s_ready = (cnt_reg != 2'(QDEPTH)) && !clearing;
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hlva_back.sv]
// back end: clear pass, per-angle vote pipeline and read-and-clear of one cell
`timescale 1ns / 1ps
`default_nettype none

module hlva_back #(
    parameter int ANGLES      = 4,
    parameter int RADIUS_BINS = 364,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire hlva_pkg::cmd_t  q_cmd,
    output logic                 q_pop,
    output logic                 clearing,
    input  wire logic            out_full,
    input  wire logic [15:0]     threshold,
    output logic                 res_valid,
    output hlva_pkg::out_t       res_data
);

    localparam int AW         = (ANGLES > 1) ? $clog2(ANGLES) : 1;
    localparam int RBW        = $clog2(RADIUS_BINS);
    localparam int CELLS      = ANGLES * RADIUS_BINS;
    localparam int CW         = $clog2(CELLS);
    localparam int ANGLE_STEP = 180 / ANGLES;
    localparam int RAD_OFF    = RADIUS_BINS / 2;
    localparam int COEF_W     = hlva_pkg::COEF_W;
    localparam int PW         = COEF_W + 8;
    localparam int SW         = PW + 1;
    localparam int RW         = SW - hlva_pkg::FRAC_BITS;
    localparam int IW         = RW + 1;
    localparam int CMPW       = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_VOTE  = 3'b100
    } back_state_t;

    back_state_t    state_reg, state_next;
    logic [CW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]  ang_cnt_reg, ang_cnt_next;
    logic [6:0]     vx_reg, vx_next;
    logic [6:0]     vy_reg, vy_next;

    // coefficient table, one entry per angle bin
    logic signed [COEF_W-1:0] cos_tab [ANGLES];
    logic signed [COEF_W-1:0] sin_tab [ANGLES];

    for (genvar g = 0; g < ANGLES; g++) begin : g_coef
        localparam logic signed [COEF_W-1:0] COS_C = hlva_pkg::unit_coef(g * ANGLE_STEP, 1'b0);
        localparam logic signed [COEF_W-1:0] SIN_C = hlva_pkg::unit_coef(g * ANGLE_STEP, 1'b1);
        assign cos_tab[g] = COS_C;
        assign sin_tab[g] = SIN_C;
    end

    // issue
    logic           iss_valid;
    logic           iss_read;
    logic           iss_ok;
    logic [AW-1:0]  iss_angle;
    logic [6:0]     iss_x;
    logic [6:0]     iss_y;
    logic [RBW-1:0] iss_radius;
    logic           read_busy;

    // stage 1: products
    logic                 s1_valid_reg, s1_read_reg, s1_ok_reg;
    logic [AW-1:0]        s1_angle_reg;
    logic [RBW-1:0]       s1_radius_reg;
    logic signed [PW-1:0] s1_px_reg, s1_py_reg;

    // stage 2: radius bin
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sum_adj;
    logic signed [RW-1:0] rad;
    logic signed [IW-1:0] idx;
    logic                 idx_ok;
    logic                 s2_valid_reg, s2_read_reg, s2_ok_reg;
    logic [AW-1:0]        s2_angle_reg;
    logic [RBW-1:0]       s2_idx_reg;
    logic [CW-1:0]        s2_addr;

    // stage 3: read-modify-write
    logic                  s3_valid_reg, s3_read_reg, s3_ok_reg;
    logic [CW-1:0]         s3_addr_reg;
    logic                  s3_fwd_reg;
    logic [COUNT_BITS-1:0] s3_fwd_data_reg;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] cur;
    logic                  s3_we;
    logic [COUNT_BITS-1:0] s3_wdata;

    logic                  ram_we;
    logic [CW-1:0]         ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;

    assign clearing  = (state_reg == ST_CLEAR);
    assign read_busy = (s1_valid_reg && s1_read_reg) || (s2_valid_reg && s2_read_reg)
                    || (s3_valid_reg && s3_read_reg);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ang_cnt_next = ang_cnt_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        q_pop        = 1'b0;
        iss_valid    = 1'b0;
        iss_read     = 1'b0;
        iss_ok       = 1'b0;
        iss_angle    = '0;
        iss_x        = vx_reg;
        iss_y        = vy_reg;
        iss_radius   = RBW'(q_cmd.radius_index);
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_cmd.is_read) begin
                        // one read in flight, and only into an empty output register
                        if (!out_full && !read_busy) begin
                            q_pop     = 1'b1;
                            iss_valid = 1'b1;
                            iss_read  = 1'b1;
                            iss_ok    = q_cmd.ok;
                            iss_angle = AW'(q_cmd.angle_index);
                        end
                    end else begin
                        q_pop     = 1'b1;
                        iss_valid = 1'b1;
                        iss_ok    = 1'b1;
                        iss_x     = q_cmd.point_x;
                        iss_y     = q_cmd.point_y;
                        vx_next   = q_cmd.point_x;
                        vy_next   = q_cmd.point_y;
                        if (ANGLES > 1) begin
                            ang_cnt_next = AW'(1);
                            state_next   = ST_VOTE;
                        end
                    end
                end
            end
            ST_VOTE: begin
                iss_valid = 1'b1;
                iss_ok    = 1'b1;
                iss_angle = ang_cnt_reg;
                if (ang_cnt_reg == AW'(ANGLES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    ang_cnt_next = ang_cnt_reg + AW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            ang_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            ang_cnt_reg  <= ang_cnt_next;
            s1_valid_reg <= iss_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1
    always_ff @(posedge aclk) begin
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        s1_read_reg   <= iss_read;
        s1_ok_reg     <= iss_ok;
        s1_angle_reg  <= iss_angle;
        s1_radius_reg <= iss_radius;
        s1_px_reg     <= PW'($signed({1'b0, iss_x})) * PW'(cos_tab[iss_angle]);
        s1_py_reg     <= PW'($signed({1'b0, iss_y})) * PW'(sin_tab[iss_angle]);
    end

    // stage 2: sum, truncate toward zero, offset and range check
    always_comb begin
        sum     = SW'(s1_px_reg) + SW'(s1_py_reg);
        sum_adj = sum + (sum[SW-1] ? SW'(65535) : SW'(0));
        rad     = sum_adj[SW-1:hlva_pkg::FRAC_BITS];
        idx     = IW'(rad) + IW'(RAD_OFF);
        idx_ok  = !idx[IW-1] && (idx < IW'(RADIUS_BINS));
    end

    always_ff @(posedge aclk) begin
        s2_read_reg  <= s1_read_reg;
        s2_ok_reg    <= s1_read_reg ? s1_ok_reg : idx_ok;
        s2_angle_reg <= s1_angle_reg;
        s2_idx_reg   <= s1_read_reg ? s1_radius_reg : idx[RBW-1:0];
    end

    assign s2_addr = CW'(s2_angle_reg) * CW'(RADIUS_BINS) + CW'(s2_idx_reg);

    // stage 3
    always_comb begin
        cur      = s3_fwd_reg ? s3_fwd_data_reg : ram_rdata;
        s3_we    = s3_valid_reg && s3_ok_reg;
        if (s3_read_reg) begin
            s3_wdata = '0;
        end else if (cur == COUNT_MAX) begin
            s3_wdata = cur;
        end else begin
            s3_wdata = cur + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        s3_read_reg     <= s2_read_reg;
        s3_ok_reg       <= s2_ok_reg;
        s3_addr_reg     <= s2_addr;
        // the ram returns old data when this cycle's write hits the cell being read
        s3_fwd_reg      <= s3_we && s2_valid_reg && s2_ok_reg && (s3_addr_reg == s2_addr);
        s3_fwd_data_reg <= s3_wdata;
    end

    always_comb begin
        if (clearing) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s3_we;
            ram_waddr = s3_addr_reg;
            ram_wdata = s3_wdata;
        end
    end

    hlva_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (s2_addr),
        .rd_data (ram_rdata)
    );

    assign res_valid           = s3_valid_reg && s3_read_reg;
    assign res_data.vote_count = s3_ok_reg ? 16'(cur) : 16'd0;
    assign res_data.is_peak    = s3_ok_reg && (CMPW'(cur) >= CMPW'(threshold));

endmodule

`default_nettype wire

[rtl/core/hough_line_vote_accumulator.sv]
// top level of the hough line vote accumulator
//
//  channel   dir  handshake           payload
//  s_        in   s_valid / s_ready   s_data  (hlva_pkg::in_t)
//  m_        out  m_valid / m_ready   m_data  (hlva_pkg::out_t)
//  cfg_      in   cfg_wr_en           cfg_wr_data (peak threshold)
//
// a vote makes one counter read-modify-write per angle, ANGLES of them, four at the
// default, on the single write port of the vote store
// a read passes the command queue, back-end stages 1 to 3 and the output register;
// the next read issues only once the previous result has been taken
// after reset a clear pass writes zero to all ANGLES*RADIUS_BINS cells
// (1456 cells at the defaults) with s_ready low
// a two-entry command queue lets the input keep moving while the back end works
`timescale 1ns / 1ps
`default_nettype none

module hough_line_vote_accumulator #(
    parameter int ANGLES      = 4,
    parameter int RADIUS_BINS = 364,
    parameter int COORD_RANGE = 128,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire hlva_pkg::in_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output hlva_pkg::out_t       m_data,
    input  wire logic            cfg_wr_en,
    input  wire logic [15:0]     cfg_wr_data
);

    logic [15:0]     threshold_reg, threshold_next;
    logic            m_valid_reg, m_valid_next;
    hlva_pkg::out_t  m_data_reg;

    logic            clearing;
    logic            q_valid;
    hlva_pkg::cmd_t  q_cmd;
    logic            q_pop;
    logic            res_valid;
    hlva_pkg::out_t  res_data;

    hlva_front #(
        .ANGLES      (ANGLES),
        .RADIUS_BINS (RADIUS_BINS),
        .COORD_RANGE (COORD_RANGE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    hlva_back #(
        .ANGLES      (ANGLES),
        .RADIUS_BINS (RADIUS_BINS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_full  (m_valid_reg),
        .threshold (threshold_reg),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    always_comb begin
        threshold_next = cfg_wr_en ? cfg_wr_data : threshold_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= 16'd20;
            m_valid_reg   <= 1'b0;
        end else begin
            threshold_reg <= threshold_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a result must never land on a result still waiting for its transfer
    a_res_into_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !m_valid_reg)
        else $error("result arrived while output register full");

    // no item taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !clearing)
        else $error("input ready during clear pass");

    // the back end only pops a queue that holds a command
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty command queue");

endmodule

`default_nettype wire

[tb/sv/hlva_tb_pkg.sv]
// scoreboard class and bin constants for the hough line vote accumulator testbench
`timescale 1ns / 1ps

package hlva_tb_pkg;

    localparam int ANGLE_BINS    = 4;
    localparam int RADIUS_BINS   = 364;
    localparam int RADIUS_OFFSET = RADIUS_BINS / 2;
    localparam int ANGLE_STEP    = 180 / ANGLE_BINS;
    localparam int COORD_LIMIT   = 128;
    localparam int COUNT_MAX     = 65535;
    localparam int DEGREES       = 180;

    class hough_scoreboard;
        logic [15:0]    vote_store [ANGLE_BINS*RADIUS_BINS];
        logic [15:0]    peak_threshold;
        hlva_pkg::out_t count_q [$];
        int             errors;
        longint         cos_q16 [DEGREES];
        longint         sin_q16 [DEGREES];

        function new();
            longint c;
            longint s;
            longint nc;
            longint ns;
            c = hlva_pkg::Q30_ONE;
            s = 0;
            // unit vector stepped one degree at a time in q2.30
            for (int k = 0; k < DEGREES; k++) begin
                cos_q16[k] = round_away(c, 14);
                sin_q16[k] = round_away(s, 14);
                nc = round_away(c * hlva_pkg::ROT_COS - s * hlva_pkg::ROT_SIN, 30);
                ns = round_away(s * hlva_pkg::ROT_COS + c * hlva_pkg::ROT_SIN, 30);
                c = nc;
                s = ns;
            end
            foreach (vote_store[i]) vote_store[i] = '0;
            peak_threshold = 16'd20;
            errors = 0;
        endfunction

        static function longint round_away(input longint v, input int sh);
            longint mag;
            mag = (v < 0) ? -v : v;
            mag = (mag + (longint'(1) << (sh - 1))) >> sh;
            return (v < 0) ? -mag : mag;
        endfunction

        // radius bin of a point at one angle, may fall outside the store
        function int radius_bin(input int x, input int y, input int a);
            longint acc;
            acc = longint'(x) * cos_q16[a*ANGLE_STEP] + longint'(y) * sin_q16[a*ANGLE_STEP];
            return int'(acc / 65536) + RADIUS_OFFSET;
        endfunction

        function void note_input(input hlva_pkg::in_t item);
            int             idx;
            int             slot;
            hlva_pkg::out_t res;
            if (item.req_type == hlva_pkg::REQ_VOTE) begin
                if (item.point_x >= COORD_LIMIT || item.point_y >= COORD_LIMIT) return;
                for (int a = 0; a < ANGLE_BINS; a++) begin
                    idx = radius_bin(item.point_x, item.point_y, a);
                    if (idx < 0 || idx >= RADIUS_BINS) continue;
                    slot = a * RADIUS_BINS + idx;
                    if (vote_store[slot] != COUNT_MAX) vote_store[slot] = vote_store[slot] + 16'd1;
                end
                return;
            end
            res = '0;
            if (item.angle_index < ANGLE_BINS && item.radius_index < RADIUS_BINS) begin
                slot = item.angle_index * RADIUS_BINS + item.radius_index;
                res.vote_count = vote_store[slot];
                res.is_peak = (vote_store[slot] >= peak_threshold);
                vote_store[slot] = '0;
            end
            count_q.push_back(res);
        endfunction

        function void check_result(input hlva_pkg::out_t got);
            hlva_pkg::out_t want;
            if (count_q.size() == 0) begin
                $error("unexpected result transfer: vote_count %0d is_peak %0d",
                       got.vote_count, got.is_peak);
                errors++;
                return;
            end
            want = count_q.pop_front();
            if (got.vote_count !== want.vote_count) begin
                $error("vote_count mismatch: expected %0d, actual %0d",
                       want.vote_count, got.vote_count);
                errors++;
            end
            if (got.is_peak !== want.is_peak) begin
                $error("is_peak mismatch: expected %0d, actual %0d", want.is_peak, got.is_peak);
                errors++;
            end
        endfunction

        function int pending();
            return count_q.size();
        endfunction
    endclass

endpackage

[tb/sv/hough_line_vote_accumulator_tb.sv]
// top-level testbench for the hough line vote accumulator
`timescale 1ns / 1ps

module hough_line_vote_accumulator_tb;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOT_SPAN       = 15;
    localparam int PHASE_ITEMS    = 350;

    logic           aclk        = 1'b0;
    logic           aresetn     = 1'b0;
    logic           s_valid     = 1'b0;
    logic           s_ready;
    hlva_pkg::in_t  s_data      = '0;
    logic           m_valid;
    logic           m_ready     = 1'b0;
    hlva_pkg::out_t m_data;
    logic           cfg_wr_en   = 1'b0;
    logic [15:0]    cfg_wr_data = '0;

    hlva_tb_pkg::hough_scoreboard sb;
    bit              tx_calm = 1'b0;
    bit              rx_calm = 1'b0;
    int              rx_hold = 0;
    int              idle_cycles = 0;

    hough_line_vote_accumulator u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic hlva_pkg::in_t random_payload();
        hlva_pkg::in_t item;
        item.req_type     = 1'($urandom);
        item.point_x      = 7'($urandom);
        item.point_y      = 7'($urandom);
        item.angle_index  = 2'($urandom);
        item.radius_index = 9'($urandom);
        return item;
    endfunction

    function automatic hlva_pkg::in_t make_random_item();
        hlva_pkg::in_t item;
        int            pick;
        int            x;
        int            y;
        int            a;
        item = random_payload();
        if ($urandom_range(0, 99) < 75) begin
            item.req_type = hlva_pkg::REQ_VOTE;
            // cluster most points so counts build up in a few cells
            if ($urandom_range(0, 99) < 85) begin
                item.point_x = 7'($urandom_range(0, HOT_SPAN));
                item.point_y = 7'($urandom_range(0, HOT_SPAN));
            end
        end else begin
            item.req_type = hlva_pkg::REQ_READ;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                x = $urandom_range(0, HOT_SPAN);
                y = $urandom_range(0, HOT_SPAN);
                a = $urandom_range(0, hlva_tb_pkg::ANGLE_BINS - 1);
                item.angle_index  = 2'(a);
                item.radius_index = 9'(sb.radius_bin(x, y, a));
            end else if (pick < 90) begin
                item.radius_index = 9'($urandom_range(0, hlva_tb_pkg::RADIUS_BINS - 1));
            end else begin
                item.radius_index = 9'($urandom_range(hlva_tb_pkg::RADIUS_BINS, 511));
            end
        end
        return item;
    endfunction

    task automatic send_item(input hlva_pkg::in_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic send_vote(input int x, input int y);
        hlva_pkg::in_t item;
        item          = random_payload();
        item.req_type = hlva_pkg::REQ_VOTE;
        item.point_x  = 7'(x);
        item.point_y  = 7'(y);
        send_item(item);
        idle_sender(pick_gap(tx_calm));
    endtask

    task automatic send_read(input int a, input int r);
        hlva_pkg::in_t item;
        item              = random_payload();
        item.req_type     = hlva_pkg::REQ_READ;
        item.angle_index  = 2'(a);
        item.radius_index = 9'(r);
        send_item(item);
        idle_sender(pick_gap(tx_calm));
    endtask

    // hold the sender until every read has come back and the vote pipe is empty
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.peak_threshold = value;
    endtask

    task automatic run_directed();
        send_read(0, hlva_tb_pkg::RADIUS_OFFSET);
        send_vote(0, 0);
        send_vote(127, 127);
        send_vote(127, 0);
        send_vote(0, 127);
        send_vote(127, 127);
        send_vote(1, 1);
        send_read(0, hlva_tb_pkg::RADIUS_OFFSET);
        send_read(1, sb.radius_bin(127, 127, 1));
        send_read(2, sb.radius_bin(0, 127, 2));
        send_read(3, hlva_tb_pkg::RADIUS_OFFSET);
        // negative radius truncates toward zero
        send_read(3, sb.radius_bin(127, 0, 3));
        send_read(0, hlva_tb_pkg::RADIUS_BINS - 1);
        send_read(0, hlva_tb_pkg::RADIUS_BINS);
        send_read(3, 511);
        send_read(3, hlva_tb_pkg::RADIUS_OFFSET);
        send_read(1, 0);
    endtask

    task automatic run_random(input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            send_item(make_random_item());
            idle_sender(pick_gap(tx_calm));
            if (i == pause_at) drain();
        end
    endtask

    // result check, input bookkeeping, receiver stalls and watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold = 0;
            idle_cycles = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_input(s_data);
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                m_ready <= 1'b0;
            end else begin
                rx_hold = pick_gap(rx_calm);
                m_ready <= (rx_hold == 0);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] phase_threshold [5];
        sb = new();
        phase_threshold[0] = 16'd1;
        phase_threshold[1] = 16'($urandom_range(2, 6));
        phase_threshold[2] = 16'd0;
        phase_threshold[3] = 16'($urandom_range(4, 12));
        phase_threshold[4] = 16'd65535;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        write_threshold(16'd2);
        run_directed();
        for (int p = 0; p < 5; p++) begin
            drain();
            write_threshold(phase_threshold[p]);
            tx_calm = (p == 2) || (p == 3);
            rx_calm = (p == 1) || (p == 3);
            run_random(PHASE_ITEMS, (p == 0) ? PHASE_ITEMS / 2 : -1);
        end
        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/hlva_pkg.sv
rtl/core/hlva_ram.sv
rtl/core/hlva_front.sv
rtl/core/hlva_back.sv
rtl/core/hough_line_vote_accumulator.sv
tb/sv/hlva_tb_pkg.sv
tb/sv/hough_line_vote_accumulator_tb.sv
